@@ hdl/tape_machine_instruction_executor_unit_defines.svh @@
// Assertion macros for the tape machine instruction executor.
`ifndef TAPE_MACHINE_INSTRUCTION_EXECUTOR_UNIT_DEFINES_SVH
`define TAPE_MACHINE_INSTRUCTION_EXECUTOR_UNIT_DEFINES_SVH

// Check a property on every edge outside reset.
`define TMIE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every edge, reset included.
`define TMIE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/tmie_pkg.sv @@
// Shared types and constants for the tape machine instruction executor.
`timescale 1ns / 1ps
package tmie_pkg;

  localparam int TAPE_CELLS_DEF    = 32768;
  localparam int LOOP_DEPTH_DEF    = 16;
  localparam int POSITION_BITS_DEF = 16;

  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_INC   = 8'h2B;
  localparam logic [7:0] CH_DEC   = 8'h2D;
  localparam logic [7:0] CH_OUT   = 8'h2E;
  localparam logic [7:0] CH_IN    = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_HALT  = 8'h21;

  localparam logic [4:0] SKIP_MAX = 5'd31;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_RIGHT,
    OP_LEFT,
    OP_INC,
    OP_DEC,
    OP_OUT,
    OP_IN,
    OP_OPEN,
    OP_CLOSE,
    OP_HALT
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] position;
    logic [15:0] next_pos;
    logic [7:0]  in_char;
  } cmd_t;

  typedef struct packed {
    logic [15:0] next_position;
    logic [7:0]  out_char;
    logic        out_valid;
    logic        halted;
    logic        done_res;
    logic        stack_overflow;
  } res_t;

endpackage

@@ hdl/tmie_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module tmie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/tmie_fifo.sv @@
// Small register queue with full and empty flags.
`timescale 1ns / 1ps
module tmie_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

@@ hdl/tmie_front.sv @@
// Front end: accept program bytes, classify them and queue them for execution.
`timescale 1ns / 1ps
module tmie_front #(
  parameter int POSITION_BITS = tmie_pkg::POSITION_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [7:0]     kind,
  input  logic [15:0]    position,
  input  logic [7:0]     in_char,
  input  logic           busy,
  output tmie_pkg::cmd_t cmd,
  output logic           cmd_valid,
  input  logic           cmd_pop
);
  import tmie_pkg::*;

  localparam int PB = (POSITION_BITS < 16) ? POSITION_BITS : 16;
  localparam logic [15:0] PMASK = 16'((17'd1 << PB) - 17'd1);

  cmd_t  dec;
  logic  q_full;
  logic  q_empty;
  logic  accept;
  logic [15:0] pos_m;

  assign pos_m  = position & PMASK;
  assign full   = q_full || busy;
  assign accept = push && !full;

  always_comb begin
    dec.position = pos_m;
    dec.next_pos = (pos_m + 16'd1) & PMASK;
    dec.in_char  = in_char;
    unique case (kind)
      CH_RIGHT: dec.op = OP_RIGHT;
      CH_LEFT:  dec.op = OP_LEFT;
      CH_INC:   dec.op = OP_INC;
      CH_DEC:   dec.op = OP_DEC;
      CH_OUT:   dec.op = OP_OUT;
      CH_IN:    dec.op = OP_IN;
      CH_OPEN:  dec.op = OP_OPEN;
      CH_CLOSE: dec.op = OP_CLOSE;
      CH_HALT:  dec.op = OP_HALT;
      default:  dec.op = OP_NOP;
    endcase
  end

  tmie_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(2)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (accept),
    .wdata(dec),
    .full (q_full),
    .pop  (cmd_pop),
    .rdata(cmd),
    .empty(q_empty)
  );

  assign cmd_valid = !q_empty;

endmodule

@@ hdl/tmie_back.sv @@
// Back end: execute queued commands against the tape, pointer and loop stack.
`timescale 1ns / 1ps
module tmie_back #(
  parameter int TAPE_CELLS    = tmie_pkg::TAPE_CELLS_DEF,
  parameter int LOOP_DEPTH    = tmie_pkg::LOOP_DEPTH_DEF,
  parameter int POSITION_BITS = tmie_pkg::POSITION_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  logic [15:0]    cfg_data,
  input  tmie_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  output tmie_pkg::res_t res,
  output logic           res_push,
  input  logic           res_full,
  output logic           busy
);
  import tmie_pkg::*;

  localparam int AW  = $clog2(TAPE_CELLS);
  localparam int LVW = $clog2(LOOP_DEPTH + 1);
  localparam int SW  = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
  localparam int PB  = (POSITION_BITS < 16) ? POSITION_BITS : 16;

  logic [AW-1:0]  clr_addr;
  logic [AW-1:0]  dp;
  logic [AW-1:0]  dp_next;
  logic [AW-1:0]  dp_inc;
  logic [AW-1:0]  dp_dec;
  logic [7:0]     cur;
  logic           fresh;
  logic [7:0]     cell_val;
  logic [7:0]     cell_new;
  logic           move;
  logic [LVW-1:0] level;
  logic [LVW-1:0] level_next;
  logic [LVW-1:0] level_m1;
  logic [PB-1:0]  starts [LOOP_DEPTH];
  logic [PB-1:0]  top;
  logic [PB-1:0]  top_inc;
  logic           stack_push;
  logic [4:0]     skip;
  logic [4:0]     skip_next;
  logic           stopped;
  logic           stopped_next;
  logic [15:0]    prog_len;
  logic           exec;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [7:0]     ram_wdata;
  logic [7:0]     ram_rdata;

  assign exec     = cmd_valid && !res_full && !busy;
  assign cmd_pop  = exec;
  assign res_push = exec;

  assign cell_val = fresh ? ram_rdata : cur;
  assign dp_inc   = (dp == AW'(TAPE_CELLS - 1)) ? '0 : dp + AW'(1);
  assign dp_dec   = (dp == '0) ? AW'(TAPE_CELLS - 1) : dp - AW'(1);
  assign level_m1 = level - LVW'(1);
  assign top      = starts[level_m1[SW-1:0]];
  assign top_inc  = top + PB'(1);

  always_comb begin
    dp_next            = dp;
    cell_new           = cell_val;
    move               = 1'b0;
    level_next         = level;
    stack_push         = 1'b0;
    skip_next          = skip;
    stopped_next       = stopped;
    res.next_position  = cmd.next_pos;
    res.out_char       = 8'd0;
    res.out_valid      = 1'b0;
    res.stack_overflow = 1'b0;
    if (stopped) begin
      res.next_position = cmd.position;
    end else if (skip != 5'd0) begin
      if (cmd.op == OP_OPEN) begin
        if (skip != SKIP_MAX) begin
          skip_next = skip + 5'd1;
        end
      end else if (cmd.op == OP_CLOSE) begin
        skip_next = skip - 5'd1;
      end
    end else begin
      unique case (cmd.op)
        OP_RIGHT: begin
          dp_next = dp_inc;
          move    = 1'b1;
        end
        OP_LEFT: begin
          dp_next = dp_dec;
          move    = 1'b1;
        end
        OP_INC: cell_new = cell_val + 8'd1;
        OP_DEC: cell_new = cell_val - 8'd1;
        OP_OUT: begin
          res.out_char  = cell_val;
          res.out_valid = 1'b1;
        end
        OP_IN: cell_new = cmd.in_char;
        OP_OPEN: begin
          if (cell_val == 8'd0) begin
            skip_next = 5'd1;
          end else if (level != LVW'(LOOP_DEPTH)) begin
            stack_push = 1'b1;
            level_next = level + LVW'(1);
          end else begin
            res.stack_overflow = 1'b1;
          end
        end
        OP_CLOSE: begin
          if (level != '0) begin
            if (cell_val != 8'd0) begin
              res.next_position = 16'(top_inc);
            end else begin
              level_next = level_m1;
            end
          end
        end
        OP_HALT: stopped_next = 1'b1;
        default: ;
      endcase
    end
    res.halted   = stopped_next;
    res.done_res = (res.next_position >= prog_len);
  end

  always_comb begin
    if (busy) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = 8'd0;
    end else begin
      ram_we    = exec && move;
      ram_waddr = dp;
      ram_wdata = cell_val;
    end
  end

  tmie_ram #(
    .WIDTH(8),
    .DEPTH(TAPE_CELLS)
  ) u_tape (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (exec && move),
    .raddr(dp_next),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
      dp       <= '0;
      cur      <= 8'd0;
      fresh    <= 1'b0;
      level    <= '0;
      skip     <= 5'd0;
      stopped  <= 1'b0;
      prog_len <= 16'd0;
    end else begin
      if (busy) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(TAPE_CELLS - 1)) begin
          busy <= 1'b0;
        end
      end
      if (cfg_write) begin
        prog_len <= cfg_data;
      end
      if (exec) begin
        dp      <= dp_next;
        level   <= level_next;
        skip    <= skip_next;
        stopped <= stopped_next;
        if (move) begin
          fresh <= 1'b1;
        end else begin
          cur   <= cell_new;
          fresh <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec && stack_push) begin
      starts[level[SW-1:0]] <= cmd.position[PB-1:0];
    end
  end

endmodule

@@ hdl/tape_machine_instruction_executor_unit.sv @@
// Top level of the tape machine instruction executor.
// Usage:
//   Input channel: present kind, position and in_char with push high; the
//   request is taken at a clock edge where full is low.
//   Result channel: while empty is low the oldest result sits on
//   next_position, out_char, out_valid, halted, done_res and stack_overflow;
//   raise pop to take it.
//   Configuration: cfg_write with cfg_data loads program_length; write it
//   only while no request is in flight.
//   Throughput: one request per cycle while the result queue is not full
//   and the tape is not being cleared, set by the execute step that reads
//   and updates the current tape cell; a pointer move writes the cell back
//   and the next cell is read from the tape RAM, registered, and forwarded
//   straight into the execute step. A taken request passes through the
//   command queue and the execute step into the result queue.
//   Reset: rst clears the pointer, loop stack level, skip and halt state,
//   then a clearing pass zeroes all TAPE_CELLS cells of the tape at one
//   cell per cycle, holding full high meanwhile.
//   Stall: with pop low, two results queue up, then two requests, then
//   full rises; nothing is dropped.
`timescale 1ns / 1ps
module tape_machine_instruction_executor_unit #(
  parameter int TAPE_CELLS    = tmie_pkg::TAPE_CELLS_DEF,
  parameter int LOOP_DEPTH    = tmie_pkg::LOOP_DEPTH_DEF,
  parameter int POSITION_BITS = tmie_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  kind,
  input  logic [15:0] position,
  input  logic [7:0]  in_char,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] next_position,
  output logic [7:0]  out_char,
  output logic        out_valid,
  output logic        halted,
  output logic        done_res,
  output logic        stack_overflow
);
  import tmie_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  res_t res;
  res_t res_q;
  logic res_push;
  logic res_full;
  logic busy;

  tmie_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .kind     (kind),
    .position (position),
    .in_char  (in_char),
    .busy     (busy),
    .cmd      (cmd),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop)
  );

  tmie_back #(
    .TAPE_CELLS   (TAPE_CELLS),
    .LOOP_DEPTH   (LOOP_DEPTH),
    .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop),
    .res      (res),
    .res_push (res_push),
    .res_full (res_full),
    .busy     (busy)
  );

  tmie_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res),
    .full (res_full),
    .pop  (pop),
    .rdata(res_q),
    .empty(empty)
  );

  assign next_position  = res_q.next_position;
  assign out_char       = res_q.out_char;
  assign out_valid      = res_q.out_valid;
  assign halted         = res_q.halted;
  assign done_res       = res_q.done_res;
  assign stack_overflow = res_q.stack_overflow;

endmodule

@@ hdl/tmie_checker.sv @@
// Port-level assertions for the tape machine instruction executor, with bind.
`timescale 1ns / 1ps
`include "tape_machine_instruction_executor_unit_defines.svh"
module tmie_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [15:0] next_position,
  input logic [7:0]  out_char,
  input logic        out_valid,
  input logic        halted,
  input logic        stack_overflow
);

  `TMIE_ASSERT_ALWAYS(a_reset_state, clk, rst |=> empty && full, "reset must empty and block")
  `TMIE_ASSERT(a_out_char_zero, clk, rst, !empty && !out_valid |-> out_char == 8'd0, "stray out_char")
  `TMIE_ASSERT(a_no_out_halted, clk, rst, !empty && halted |-> !out_valid && !stack_overflow, "activity after halt")
  `TMIE_ASSERT(a_halt_sticky, clk, rst, !empty && halted |=> empty || halted, "halt dropped")
  `TMIE_ASSERT(a_result_holds, clk, rst, !empty && !pop |=> !empty && $stable(next_position), "result lost")

endmodule

bind tape_machine_instruction_executor_unit tmie_checker u_tmie_checker (
  .clk           (clk),
  .rst           (rst),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .next_position (next_position),
  .out_char      (out_char),
  .out_valid     (out_valid),
  .halted        (halted),
  .stack_overflow(stack_overflow)
);

@@ sim/tape_machine_instruction_executor_unit_tb.sv @@
// Self-checking testbench for the tape machine instruction executor.
`timescale 1ns / 1ps
module tape_machine_instruction_executor_unit_tb;
  import tmie_pkg::*;

  localparam int MAX_CYCLES   = 600000;
  localparam int RANDOM_UNTIL = 1500;
  localparam int PTR_BITS     = $clog2(TAPE_CELLS_DEF);

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  kind;
  logic [15:0] position;
  logic [7:0]  in_char;
  logic        cfg_write;
  logic [15:0] cfg_data;
  logic        empty;
  logic        pop;
  logic [15:0] next_position;
  logic [7:0]  out_char;
  logic        out_valid;
  logic        halted;
  logic        done_res;
  logic        stack_overflow;

  logic [7:0]          tape_model [TAPE_CELLS_DEF];
  logic [PTR_BITS-1:0] data_ptr;
  logic [15:0]         loop_stack [LOOP_DEPTH_DEF];
  int                  loop_level;
  logic [4:0]          skip_level;
  logic                halted_state;
  logic [15:0]         prog_length;

  res_t        expected_q [$];
  res_t        last_res;
  logic [7:0]  prog_bytes [64];
  bit          idle_on;
  int          items_sent;
  int          errors;
  int          cycles;
  int          hold_req_cnt;
  int          hold_ack_cnt;
  int          hold_left;
  int          pop_gap;

  tape_machine_instruction_executor_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .kind           (kind),
    .position       (position),
    .in_char        (in_char),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .empty          (empty),
    .pop            (pop),
    .next_position  (next_position),
    .out_char       (out_char),
    .out_valid      (out_valid),
    .halted         (halted),
    .done_res       (done_res),
    .stack_overflow (stack_overflow)
  );

  always #5 clk = ~clk;

  function automatic res_t execute_command(logic [7:0] k, logic [15:0] p, logic [7:0] c);
    res_t r;
    r = '0;
    r.next_position = p + 16'd1;
    if (halted_state) begin
      r.next_position = p;
    end else if (skip_level != 5'd0) begin
      if (k == CH_OPEN) begin
        if (skip_level < SKIP_MAX) skip_level = skip_level + 5'd1;
      end else if (k == CH_CLOSE) begin
        skip_level = skip_level - 5'd1;
      end
    end else begin
      case (k)
        CH_RIGHT: data_ptr = data_ptr + 1'b1;
        CH_LEFT:  data_ptr = data_ptr - 1'b1;
        CH_INC:   tape_model[data_ptr] = tape_model[data_ptr] + 8'd1;
        CH_DEC:   tape_model[data_ptr] = tape_model[data_ptr] - 8'd1;
        CH_OUT: begin
          r.out_char  = tape_model[data_ptr];
          r.out_valid = 1'b1;
        end
        CH_IN:    tape_model[data_ptr] = c;
        CH_OPEN: begin
          if (tape_model[data_ptr] == 8'd0) begin
            skip_level = 5'd1;
          end else if (loop_level < LOOP_DEPTH_DEF) begin
            loop_stack[loop_level] = p;
            loop_level++;
          end else begin
            r.stack_overflow = 1'b1;
          end
        end
        CH_CLOSE: begin
          if (loop_level != 0) begin
            if (tape_model[data_ptr] != 8'd0) begin
              r.next_position = loop_stack[loop_level - 1] + 16'd1;
            end else begin
              loop_level--;
            end
          end
        end
        CH_HALT:  halted_state = 1'b1;
        default: ;
      endcase
    end
    r.halted   = halted_state;
    r.done_res = (r.next_position >= prog_length);
    return r;
  endfunction

  function automatic logic [7:0] plain_op();
    case ($urandom_range(0, 5))
      0:       return CH_RIGHT;
      1:       return CH_LEFT;
      2:       return CH_INC;
      3:       return CH_DEC;
      4:       return CH_OUT;
      default: return CH_IN;
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == CH_HALT) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic send_cmd(logic [7:0] k, logic [15:0] p, logic [7:0] c);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push     <= 1'b1;
    kind     <= k;
    position <= p;
    in_char  <= c;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    last_res = execute_command(k, p, c);
    expected_q.push_back(last_res);
    items_sent++;
  endtask

  task automatic settle_block();
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_length(logic [15:0] v);
    settle_block();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    prog_length = v;
  endtask

  task automatic test_basic_commands();
    write_length(16'd12);
    send_cmd(CH_INC, 16'd0, 8'h00);
    send_cmd(CH_OUT, 16'd1, 8'hFF);
    send_cmd(CH_DEC, 16'd2, 8'h55);
    send_cmd(CH_DEC, 16'd3, 8'hAA);
    send_cmd(CH_OUT, 16'd4, 8'h00);
    send_cmd(CH_IN, 16'd5, 8'hFF);
    send_cmd(CH_OUT, 16'd6, 8'h00);
    send_cmd(CH_IN, 16'd7, 8'h00);
    send_cmd(CH_LEFT, 16'd8, 8'h00);
    send_cmd(CH_INC, 16'd9, 8'h00);
    send_cmd(CH_OUT, 16'd10, 8'h00);
    send_cmd(CH_RIGHT, 16'd11, 8'h00);
    send_cmd(CH_OUT, 16'd12, 8'h00);
    send_cmd(8'h00, 16'd13, 8'h00);
    send_cmd(8'hFF, 16'hFFFF, 8'hFF);
    send_cmd(CH_CLOSE, 16'd20, 8'h00);
    send_cmd(CH_OPEN, 16'd21, 8'h00);
    send_cmd(CH_HALT, 16'd22, 8'h00);
    send_cmd(CH_INC, 16'd23, 8'h00);
    send_cmd(CH_CLOSE, 16'd24, 8'h00);
    send_cmd(CH_OUT, 16'd25, 8'h00);
    send_cmd(CH_INC, 16'd26, 8'h00);
    send_cmd(CH_OPEN, 16'hFFFF, 8'h00);
    send_cmd(CH_CLOSE, 16'd5, 8'h00);
    send_cmd(CH_DEC, 16'd0, 8'h00);
    send_cmd(CH_CLOSE, 16'd1, 8'h00);
  endtask

  task automatic test_loop_stack_limit();
    send_cmd(CH_IN, 16'd99, 8'h01);
    for (int i = 0; i <= LOOP_DEPTH_DEF; i++) send_cmd(CH_OPEN, 16'd100 + i[15:0], 8'h00);
    send_cmd(CH_CLOSE, 16'd200, 8'h00);
    send_cmd(CH_IN, 16'd201, 8'h00);
    for (int i = 0; i <= LOOP_DEPTH_DEF; i++) send_cmd(CH_CLOSE, 16'd300 + i[15:0], 8'h00);
  endtask

  task automatic test_skip_saturation();
    send_cmd(CH_IN, 16'd400, 8'h00);
    send_cmd(CH_OPEN, 16'd401, 8'h00);
    for (int i = 0; i < 32; i++) send_cmd(CH_OPEN, 16'd402 + i[15:0], 8'h00);
    for (int i = 0; i < 30; i++) send_cmd(CH_CLOSE, 16'd440 + i[15:0], 8'h00);
    send_cmd(CH_OUT, 16'd480, 8'h00);
    send_cmd(CH_CLOSE, 16'd481, 8'h00);
    send_cmd(CH_OUT, 16'd482, 8'h00);
  endtask

  task automatic test_program_length();
    write_length(16'd0);
    send_cmd(CH_RIGHT, 16'd0, 8'h00);
    send_cmd(CH_OUT, 16'd500, 8'h00);
    write_length(16'hFFFF);
    send_cmd(CH_LEFT, 16'hFFFE, 8'h00);
    send_cmd(CH_OUT, 16'hFFFF, 8'h00);
    send_cmd(CH_INC, 16'hFFFD, 8'h00);
    write_length(16'h8000);
    send_cmd(CH_DEC, 16'h7FFF, 8'h00);
    send_cmd(CH_OUT, 16'h7FFE, 8'h00);
    write_length(16'd1);
    send_cmd(CH_OUT, 16'd0, 8'h00);
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_req_cnt++;
    for (int i = 0; i < 40; i++) begin
      send_cmd(($urandom_range(0, 3) == 0) ? noise_byte() : plain_op(),
               16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
    end
    idle_on = 1'b1;
  endtask

  task automatic build_program(int len);
    int open_cnt;
    int roll;
    open_cnt = 0;
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(0, 9);
      if (len - i <= open_cnt) begin
        prog_bytes[i] = CH_CLOSE;
        open_cnt--;
      end else if (roll <= 1 && open_cnt < 5 && len - i > open_cnt + 2) begin
        prog_bytes[i] = CH_OPEN;
        open_cnt++;
      end else if (roll == 2 && open_cnt > 0) begin
        prog_bytes[i] = CH_CLOSE;
        open_cnt--;
      end else if (roll == 3 && $urandom_range(0, 2) == 0) begin
        prog_bytes[i] = noise_byte();
      end else begin
        prog_bytes[i] = plain_op();
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      prog_bytes[$urandom_range(0, len - 1)] = $urandom_range(0, 1) ? CH_OPEN : CH_CLOSE;
    end
  endtask

  task automatic run_program(int len, logic [15:0] base, int step_cap);
    logic [15:0] pc;
    logic [15:0] offs;
    int          steps;
    pc    = base;
    offs  = 16'd0;
    steps = 0;
    while (offs < len && steps < step_cap) begin
      if ($urandom_range(0, 7) == 0) begin
        send_cmd(noise_byte(), 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      end
      send_cmd(prog_bytes[offs], pc, 8'($urandom_range(0, 255)));
      pc = last_res.next_position;
      offs = pc - base;
      steps++;
    end
    while (skip_level != 5'd0) send_cmd(CH_CLOSE, 16'($urandom_range(0, 65535)), 8'h00);
    if (loop_level != 0 && $urandom_range(0, 1) == 0) begin
      send_cmd(CH_IN, 16'($urandom_range(0, 65535)), 8'h00);
      while (loop_level != 0) send_cmd(CH_CLOSE, 16'($urandom_range(0, 65535)), 8'h00);
    end
  endtask

  task automatic test_random_programs();
    int          len;
    logic [15:0] base;
    while (items_sent < RANDOM_UNTIL) begin
      len = $urandom_range(3, 48);
      build_program(len);
      if ($urandom_range(0, 5) == 0) base = 16'hFFFF - 16'(len / 2);
      else base = 16'($urandom_range(0, 300));
      case ($urandom_range(0, 5))
        0:       write_length(16'd0);
        1:       write_length(16'hFFFF);
        2:       write_length(16'($urandom_range(0, 65535)));
        default: write_length(base + len[15:0]);
      endcase
      if (items_sent > RANDOM_UNTIL - 200) idle_on = 1'b0;
      run_program(len, base, 80);
    end
  endtask

  task automatic test_halt();
    idle_on = 1'b0;
    send_cmd(CH_INC, 16'd600, 8'h00);
    send_cmd(CH_HALT, 16'd601, 8'h00);
    send_cmd(CH_RIGHT, 16'd602, 8'h00);
    send_cmd(CH_LEFT, 16'd603, 8'h00);
    send_cmd(CH_INC, 16'd604, 8'h00);
    send_cmd(CH_DEC, 16'd605, 8'h00);
    send_cmd(CH_OUT, 16'd606, 8'h00);
    send_cmd(CH_IN, 16'd607, 8'hA5);
    send_cmd(CH_OPEN, 16'd608, 8'h00);
    send_cmd(CH_CLOSE, 16'd609, 8'h00);
    send_cmd(CH_HALT, 16'hFFFF, 8'h00);
    for (int i = 0; i < 8; i++) begin
      send_cmd(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
               8'($urandom_range(0, 255)));
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("FAIL tape_machine_instruction_executor_unit");
      $finish;
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && pop && empty === 1'b0) begin
      got.next_position  = next_position;
      got.out_char       = out_char;
      got.out_valid      = out_valid;
      got.halted         = halted;
      got.done_res       = done_res;
      got.stack_overflow = stack_overflow;
      if (expected_q.size() == 0) begin
        if (errors < 10) $display("unexpected result: next_position=%0d", got.next_position);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.next_position !== want.next_position || got.out_char !== want.out_char ||
            got.out_valid !== want.out_valid || got.halted !== want.halted ||
            got.done_res !== want.done_res || got.stack_overflow !== want.stack_overflow) begin
          if (errors < 10) begin
            $display("mismatch: exp next=%0d char=%0d valid=%0b halt=%0b done=%0b ovf=%0b",
                     want.next_position, want.out_char, want.out_valid, want.halted,
                     want.done_res, want.stack_overflow);
            $display("          got next=%0d char=%0d valid=%0b halt=%0b done=%0b ovf=%0b",
                     got.next_position, got.out_char, got.out_valid, got.halted,
                     got.done_res, got.stack_overflow);
          end
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_ack_cnt != hold_req_cnt) begin
      hold_ack_cnt = hold_req_cnt;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop_gap--;
      pop <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      pop_gap = $urandom_range(0, 6);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    clk       = 1'b0;
    rst       <= 1'b1;
    push      <= 1'b0;
    pop       <= 1'b0;
    kind      <= 8'h00;
    position  <= 16'h0000;
    in_char   <= 8'h00;
    cfg_write <= 1'b0;
    cfg_data  <= 16'h0000;
    for (int i = 0; i < TAPE_CELLS_DEF; i++) tape_model[i] = 8'h00;
    for (int i = 0; i < LOOP_DEPTH_DEF; i++) loop_stack[i] = 16'h0000;
    data_ptr     = '0;
    loop_level   = 0;
    skip_level   = 5'd0;
    halted_state = 1'b0;
    prog_length  = 16'd0;
    idle_on      = 1'b1;
    items_sent   = 0;
    errors       = 0;
    cycles       = 0;
    hold_req_cnt = 0;
    hold_ack_cnt = 0;
    hold_left    = 0;
    pop_gap      = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_basic_commands();
    test_loop_stack_limit();
    test_skip_saturation();
    test_program_length();
    test_backpressure();
    test_random_programs();
    test_halt();

    settle_block();
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS tape_machine_instruction_executor_unit");
    end else begin
      $display("FAIL tape_machine_instruction_executor_unit");
    end
    $finish;
  end

endmodule
